// ===== rtl/core/clfl_pkg.sv =====
// ----------------------------------------------------------------------------
// clfl_pkg
// Shared types, microcode fields and step addresses for the circular list
// with free list manager.
// ----------------------------------------------------------------------------
package clfl_pkg;

  // request and result payloads
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
  } out_t;

  // request codes
  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_BACK  = 2'd1,
    ACT_REM_FRONT = 2'd2,
    ACT_REM_BACK  = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // microcode step address
  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_DISP      = step_t'(0);
  localparam step_t S_INS_CHK   = step_t'(1);
  localparam step_t S_INS_TAKE  = step_t'(2);
  localparam step_t S_INS_WALK  = step_t'(3);
  localparam step_t S_INS_LINK  = step_t'(4);
  localparam step_t S_INS_TAIL  = step_t'(5);
  localparam step_t S_INS_HEAD  = step_t'(6);
  localparam step_t S_INS_FIRST = step_t'(7);
  localparam step_t S_REM       = step_t'(8);
  localparam step_t S_REM_CHK   = step_t'(9);
  localparam step_t S_REM_WALK  = step_t'(10);
  localparam step_t S_REM_SEL   = step_t'(11);
  localparam step_t S_REM_FRONT = step_t'(12);
  localparam step_t S_REM_BACK  = step_t'(13);
  localparam step_t S_REM_FREE  = step_t'(14);
  localparam step_t S_REM_ONLY  = step_t'(15);
  localparam step_t S_FIN       = step_t'(16);
  localparam step_t S_OVF       = step_t'(17);
  localparam step_t S_EMPTY     = step_t'(18);

  // link memory read address source
  typedef enum logic [1:0] {
    RD_FREE = 2'd0,
    RD_HEAD = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  // link memory write address source
  typedef enum logic [1:0] {
    WA_SLOT = 2'd0,
    WA_CUR  = 2'd1,
    WA_PRV  = 2'd2
  } wa_sel_e;

  // link memory write data source
  typedef enum logic [1:0] {
    WD_SLOT = 2'd0,
    WD_HEAD = 2'd1,
    WD_TMP  = 2'd2,
    WD_FREE = 2'd3
  } wd_sel_e;

  // slot register load source
  typedef enum logic [1:0] {
    SL_HOLD = 2'd0,
    SL_FREE = 2'd1,
    SL_HEAD = 2'd2,
    SL_CUR  = 2'd3
  } slot_sel_e;

  // list head load source
  typedef enum logic [1:0] {
    HD_HOLD = 2'd0,
    HD_SLOT = 2'd1,
    HD_TMP  = 2'd2,
    HD_NIL  = 2'd3
  } head_sel_e;

  // free head load source
  typedef enum logic [1:0] {
    FR_HOLD = 2'd0,
    FR_NEXT = 2'd1,
    FR_SLOT = 2'd2
  } free_sel_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE      = 3'd0,
    C_ALWAYS    = 3'd1,
    C_REMOVE    = 3'd2,
    C_FREE_NIL  = 3'd3,
    C_HEAD_NIL  = 3'd4,
    C_WALK_CONT = 3'd5,
    C_SINGLE    = 3'd6,
    C_BACK      = 3'd7
  } cond_e;

  // sequencer state
  typedef enum logic {
    SQ_IDLE = 1'b0,
    SQ_RUN  = 1'b1
  } seq_state_e;

  // one control word
  typedef struct packed {
    rd_sel_e   rd_sel;
    logic      link_we;
    wa_sel_e   wa_sel;
    wd_sel_e   wd_sel;
    logic      val_we;
    slot_sel_e slot_sel;
    head_sel_e head_sel;
    free_sel_e free_sel;
    logic      cur_ld;
    logic      walk;
    logic      tmp_ld;
    cond_e     cond;
    step_t     target;
    logic      done;
    status_e   status;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{
    rd_sel:   RD_FREE,
    link_we:  1'b0,
    wa_sel:   WA_SLOT,
    wd_sel:   WD_SLOT,
    val_we:   1'b0,
    slot_sel: SL_HOLD,
    head_sel: HD_HOLD,
    free_sel: FR_HOLD,
    cur_ld:   1'b0,
    walk:     1'b0,
    tmp_ld:   1'b0,
    cond:     C_NONE,
    target:   S_DISP,
    done:     1'b0,
    status:   ST_OK
  };

  // datapath status seen by the sequencer
  typedef struct packed {
    logic remove;
    logic back;
    logic free_nil;
    logic head_nil;
    logic walk_end;
    logic single;
  } flags_t;

endpackage

// ===== rtl/core/clfl_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// clfl_ucode_rom
// Read-only microprogram: one control word per step address.
// ----------------------------------------------------------------------------
module clfl_ucode_rom
  import clfl_pkg::*;
(
  input  step_t step_i,
  output ctl_t  ctl_o
);

  // program table
  always_comb begin
    ctl_o = CTL_NOP;
    unique case (step_i)
      // pick insert or removal, remember free head as candidate slot
      S_DISP: begin
        ctl_o.slot_sel = SL_FREE;
        ctl_o.cond     = C_REMOVE;
        ctl_o.target   = S_REM;
      end
      S_INS_CHK: begin
        ctl_o.cond   = C_FREE_NIL;
        ctl_o.target = S_OVF;
      end
      // pop free list, store value, start walk at head
      S_INS_TAKE: begin
        ctl_o.free_sel = FR_NEXT;
        ctl_o.val_we   = 1'b1;
        ctl_o.rd_sel   = RD_HEAD;
        ctl_o.cur_ld   = 1'b1;
        ctl_o.cond     = C_HEAD_NIL;
        ctl_o.target   = S_INS_FIRST;
      end
      S_INS_WALK: begin
        ctl_o.rd_sel = RD_NEXT;
        ctl_o.walk   = 1'b1;
        ctl_o.cond   = C_WALK_CONT;
        ctl_o.target = S_INS_WALK;
      end
      S_INS_LINK: begin
        ctl_o.link_we = 1'b1;
        ctl_o.wa_sel  = WA_SLOT;
        ctl_o.wd_sel  = WD_HEAD;
      end
      S_INS_TAIL: begin
        ctl_o.link_we = 1'b1;
        ctl_o.wa_sel  = WA_CUR;
        ctl_o.wd_sel  = WD_SLOT;
        ctl_o.cond    = C_BACK;
        ctl_o.target  = S_FIN;
      end
      S_INS_HEAD: begin
        ctl_o.head_sel = HD_SLOT;
        ctl_o.done     = 1'b1;
      end
      // first entry links to itself
      S_INS_FIRST: begin
        ctl_o.link_we  = 1'b1;
        ctl_o.wa_sel   = WA_SLOT;
        ctl_o.wd_sel   = WD_SLOT;
        ctl_o.head_sel = HD_SLOT;
        ctl_o.done     = 1'b1;
      end
      // removal: read link of head
      S_REM: begin
        ctl_o.rd_sel   = RD_HEAD;
        ctl_o.slot_sel = SL_HEAD;
        ctl_o.cur_ld   = 1'b1;
        ctl_o.cond     = C_HEAD_NIL;
        ctl_o.target   = S_EMPTY;
      end
      S_REM_CHK: begin
        ctl_o.rd_sel = RD_HEAD;
        ctl_o.tmp_ld = 1'b1;
        ctl_o.cond   = C_SINGLE;
        ctl_o.target = S_REM_ONLY;
      end
      S_REM_WALK: begin
        ctl_o.rd_sel = RD_NEXT;
        ctl_o.walk   = 1'b1;
        ctl_o.cond   = C_WALK_CONT;
        ctl_o.target = S_REM_WALK;
      end
      S_REM_SEL: begin
        ctl_o.cond   = C_BACK;
        ctl_o.target = S_REM_BACK;
      end
      // last entry now points past the old head
      S_REM_FRONT: begin
        ctl_o.link_we  = 1'b1;
        ctl_o.wa_sel   = WA_CUR;
        ctl_o.wd_sel   = WD_TMP;
        ctl_o.head_sel = HD_TMP;
        ctl_o.cond     = C_ALWAYS;
        ctl_o.target   = S_REM_FREE;
      end
      // predecessor of the last entry closes the ring
      S_REM_BACK: begin
        ctl_o.link_we  = 1'b1;
        ctl_o.wa_sel   = WA_PRV;
        ctl_o.wd_sel   = WD_HEAD;
        ctl_o.slot_sel = SL_CUR;
      end
      // push freed slot onto free list
      S_REM_FREE: begin
        ctl_o.link_we  = 1'b1;
        ctl_o.wa_sel   = WA_SLOT;
        ctl_o.wd_sel   = WD_FREE;
        ctl_o.free_sel = FR_SLOT;
        ctl_o.done     = 1'b1;
      end
      S_REM_ONLY: begin
        ctl_o.head_sel = HD_NIL;
        ctl_o.cond     = C_ALWAYS;
        ctl_o.target   = S_REM_FREE;
      end
      S_FIN: begin
        ctl_o.done = 1'b1;
      end
      S_OVF: begin
        ctl_o.done   = 1'b1;
        ctl_o.status = ST_OVERFLOW;
      end
      S_EMPTY: begin
        ctl_o.done   = 1'b1;
        ctl_o.status = ST_EMPTY;
      end
      default: begin
        ctl_o.done = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/core/clfl_sequencer.sv =====
// ----------------------------------------------------------------------------
// clfl_sequencer
// Step counter with conditional jumps over the microprogram.
// ----------------------------------------------------------------------------
module clfl_sequencer
  import clfl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  logic   clr_i,
  input  flags_t flags_i,
  output logic   accept_o,
  output logic   busy_o,
  output ctl_t   ctl_o
);

  seq_state_e state_q, state_d;
  step_t      step_q, step_d;
  ctl_t       rom_ctl;
  logic       take;

  clfl_ucode_rom u_rom (
    .step_i (step_q),
    .ctl_o  (rom_ctl)
  );

  assign accept_o = start_i && (state_q == SQ_IDLE) && !clr_i;

  // jump condition
  always_comb begin
    unique case (rom_ctl.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_REMOVE:    take = flags_i.remove;
      C_FREE_NIL:  take = flags_i.free_nil;
      C_HEAD_NIL:  take = flags_i.head_nil;
      C_WALK_CONT: take = !flags_i.walk_end;
      C_SINGLE:    take = flags_i.single;
      C_BACK:      take = flags_i.back;
      default:     take = 1'b0;
    endcase
  end

  // next state and step
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (accept_o) begin
          state_d = SQ_RUN;
          step_d  = S_DISP;
        end
      end
      SQ_RUN: begin
        if (rom_ctl.done) begin
          state_d = SQ_IDLE;
        end else if (take) begin
          step_d = rom_ctl.target;
        end else begin
          step_d = step_q + step_t'(1);
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o  = (state_q == SQ_RUN) ? rom_ctl : CTL_NOP;
    busy_o = (state_q == SQ_RUN) || clr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      step_q  <= S_DISP;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== rtl/core/clfl_datapath.sv =====
// ----------------------------------------------------------------------------
// clfl_datapath
// Link and value memories, list pointers, walk registers and result register.
// ----------------------------------------------------------------------------
module clfl_datapath
  import clfl_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   accept_i,
  input  in_t    req_i,
  input  ctl_t   ctl_i,
  output flags_t flags_o,
  output logic   clr_o,
  output logic   done_o,
  output out_t   res_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  logic [LW-1:0] link_mem [SLOTS];
  logic [31:0]   val_mem  [SLOTS];

  logic [1:0]         act_q;
  logic signed [31:0] val_q;
  logic [LW-1:0]      head_q, head_d;
  logic [LW-1:0]      free_q, free_d;
  logic [LW-1:0]      slot_q, cur_q, prv_q, tmp_q, rdata_q;
  logic               clr_q;
  logic [IW-1:0]      clr_cnt_q;
  logic               done_q;
  out_t               res_q;

  logic [LW-1:0] rd_addr, wr_addr, wr_data;
  logic [IW-1:0] rd_idx, mem_idx;
  logic [LW-1:0] mem_data;
  logic          mem_we;
  logic          walk_end;

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      act_q <= req_i.action;
      val_q <= req_i.value;
    end
  end

  // status flags
  assign walk_end = (rdata_q == head_q) || (rdata_q >= NIL);
  always_comb begin
    flags_o.remove   = (act_q == ACT_REM_FRONT) || (act_q == ACT_REM_BACK);
    flags_o.back     = (act_q == ACT_INS_BACK) || (act_q == ACT_REM_BACK);
    flags_o.free_nil = (free_q >= NIL);
    flags_o.head_nil = (head_q >= NIL);
    flags_o.walk_end = walk_end;
    flags_o.single   = (rdata_q == head_q);
  end

  // read address
  always_comb begin
    unique case (ctl_i.rd_sel)
      RD_FREE: rd_addr = free_q;
      RD_HEAD: rd_addr = head_q;
      RD_NEXT: rd_addr = rdata_q;
      default: rd_addr = free_q;
    endcase
    rd_idx = (rd_addr < NIL) ? rd_addr[IW-1:0] : '0;
  end

  // write address and data
  always_comb begin
    unique case (ctl_i.wa_sel)
      WA_SLOT: wr_addr = slot_q;
      WA_CUR:  wr_addr = cur_q;
      WA_PRV:  wr_addr = prv_q;
      default: wr_addr = slot_q;
    endcase
    unique case (ctl_i.wd_sel)
      WD_SLOT: wr_data = slot_q;
      WD_HEAD: wr_data = head_q;
      WD_TMP:  wr_data = tmp_q;
      WD_FREE: wr_data = free_q;
      default: wr_data = slot_q;
    endcase
    if (clr_q) begin
      mem_we   = 1'b1;
      mem_idx  = clr_cnt_q;
      mem_data = LW'(clr_cnt_q) + LW'(1);
    end else begin
      mem_we   = ctl_i.link_we && (wr_addr < NIL);
      mem_idx  = wr_addr[IW-1:0];
      mem_data = wr_data;
    end
  end

  // link memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_idx] <= mem_data;
    end
    rdata_q <= link_mem[rd_idx];
  end

  // value memory, written only
  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) begin
      val_mem[slot_q[IW-1:0]] <= val_q;
    end
  end

  // head and free pointer updates
  always_comb begin
    unique case (ctl_i.head_sel)
      HD_HOLD: head_d = head_q;
      HD_SLOT: head_d = slot_q;
      HD_TMP:  head_d = tmp_q;
      HD_NIL:  head_d = NIL;
      default: head_d = head_q;
    endcase
    unique case (ctl_i.free_sel)
      FR_HOLD: free_d = free_q;
      FR_NEXT: free_d = rdata_q;
      FR_SLOT: free_d = slot_q;
      default: free_d = free_q;
    endcase
  end

  // list pointers and clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= NIL;
      free_q    <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      head_q <= head_d;
      free_q <= free_d;
      if (clr_q) begin
        if (clr_cnt_q == IW'(SLOTS - 1)) begin
          clr_q <= 1'b0;
        end
        clr_cnt_q <= clr_cnt_q + IW'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.slot_sel)
      SL_HOLD: slot_q <= slot_q;
      SL_FREE: slot_q <= free_q;
      SL_HEAD: slot_q <= head_q;
      SL_CUR:  slot_q <= cur_q;
      default: slot_q <= slot_q;
    endcase
    if (ctl_i.cur_ld) begin
      cur_q <= head_q;
    end else if (ctl_i.walk && !walk_end) begin
      prv_q <= cur_q;
      cur_q <= rdata_q;
    end
    if (ctl_i.tmp_ld) begin
      tmp_q <= rdata_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.done) begin
      res_q.status <= ctl_i.status;
      res_q.slot   <= (ctl_i.status == ST_OK) ? 4'(slot_q) : 4'd0;
    end
  end

  assign clr_o  = clr_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/circular_list_free_list_manager_core.sv =====
// ----------------------------------------------------------------------------
// circular_list_free_list_manager_core
// Circular singly linked list over a fixed slot store with a free list,
// run by a microprogrammed sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_i.action, req_i.value) is transferred at a rising edge
//   with start_i high and busy_o low. busy_o stays high until the request
//   finishes; one result (res_o.status, res_o.slot) is shown for exactly one
//   cycle with done_o high. The receiver cannot stall, so nothing backs up.
//   An insert into a nonempty list and a removal from a list of two or
//   more entries walk from the head to the last entry, one link read per
//   cycle. busy_o drops in the cycle that done_o is high, so the next
//   request can be transferred at the edge that ends it; a new request is
//   taken only once the last one has finished.
//   After reset the link memory is rebuilt by a pass over every slot (each
//   slot links to the next, the last to null) while busy_o is high; the
//   list is empty and every slot is free.
// ----------------------------------------------------------------------------
module circular_list_free_list_manager_core
  import clfl_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  req_i,
  output logic busy_o,
  output logic done_o,
  output out_t res_o
);

  flags_t flags;
  ctl_t   ctl;
  logic   accept;
  logic   clr;

  clfl_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .clr_i    (clr),
    .flags_i  (flags),
    .accept_o (accept),
    .busy_o   (busy_o),
    .ctl_o    (ctl)
  );

  clfl_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .ctl_i    (ctl),
    .flags_o  (flags),
    .clr_o    (clr),
    .done_o   (done_o),
    .res_o    (res_o)
  );

  // a transfer always starts a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("busy not raised after request transfer");

  // one result per request, never in two adjacent cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // failed requests report slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ST_OK)) |-> (res_o.slot == 4'd0))
    else $error("nonzero slot on failed request");

  // no result while the link memory is being rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |-> !ctl.done)
    else $error("microprogram finished during clearing pass");

endmodule
